### design/djrw_pkg.sv
package djrw_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_ACTIVE_TIMEOUT   = 3'd0;
  localparam logic [2:0] CFG_INACTIVE_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_DEADBAND_X       = 3'd2;
  localparam logic [2:0] CFG_DEADBAND_Y       = 3'd3;
  localparam logic [2:0] CFG_CRITICAL_MODE    = 3'd4;

  // Item commands
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Ring select
  localparam logic RING_DRIVE = 1'b0;
  localparam logic RING_DOME  = 1'b1;

  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  // Button bit positions
  localparam int B_JOY  = 0;
  localparam int B_TRIG = 1;
  localparam int B_P1   = 2;
  localparam int B_P2   = 3;
  localparam int B_P3   = 4;
  localparam int B_P4   = 5;
  localparam int B_REC  = 6;

  typedef struct packed {
    logic              cmd;
    logic              ring_sel;
    logic signed [7:0] joy_x;
    logic signed [7:0] joy_y;
    logic [7:0]        buttons;
    logic              drive_connected;
    logic              dome_connected;
  } in_t;

  typedef struct packed {
    logic              fault;
    logic              estop_pulse;
    logic signed [7:0] drive_x;
    logic signed [7:0] drive_y;
    logic signed [7:0] dome_x;
    logic signed [7:0] dome_y;
    logic [4:0]        trigger_code;
  } out_t;

  // Raw state after one item, handed from front to back
  typedef struct packed {
    logic              fault;
    logic              estop_pulse;
    logic signed [7:0] drv_x;
    logic signed [7:0] drv_y;
    logic [7:0]        drv_btn;
    logic signed [7:0] dom_x;
    logic signed [7:0] dom_y;
    logic [7:0]        dom_btn;
  } snap_t;

  // Shaping settings used by the back end
  typedef struct packed {
    logic [6:0] deadband_x;
    logic [6:0] deadband_y;
  } shape_cfg_t;

  // Deadband, then trunc(raw * 100 / 127) on the magnitude
  function automatic logic signed [7:0] shape_axis(logic signed [7:0] raw, logic [6:0] band);
    logic [7:0]  mag;
    logic [13:0] prod;
    logic [16:0] est;
    logic [6:0]  q0;
    logic [13:0] rem;
    logic [6:0]  q;
    mag  = raw[7] ? 8'(~raw + 8'sd1) : 8'(raw);
    prod = (14'(mag) << 6) + (14'(mag) << 5) + (14'(mag) << 2);
    // reciprocal estimate is exact or one low
    est  = 17'(mag) * 17'd806;
    q0   = est[16:10];
    rem  = prod - ((14'(q0) << 7) - 14'(q0));
    q    = (rem >= 14'd127) ? 7'(q0 + 7'd1) : q0;
    if (mag < {1'b0, band}) begin
      return 8'sd0;
    end
    return raw[7] ? 8'(-$signed({1'b0, q})) : 8'({1'b0, q});
  endfunction

  // Priority-encoded button chord
  function automatic logic [4:0] chord_code(logic [7:0] r, logic [7:0] l);
    logic [4:0] code;
    logic [6:0] single_pos [7];
    logic [6:0] both_pos   [6];
    logic [3:0] push_pos   [4];
    code = 5'd0;
    single_pos = '{7'(1 << B_TRIG), 7'(1 << B_P1), 7'(1 << B_P2), 7'(1 << B_P3),
                   7'(1 << B_P4), 7'(1 << B_JOY), 7'(1 << B_REC)};
    both_pos   = '{7'(1 << B_TRIG), 7'(1 << B_P1), 7'(1 << B_P2), 7'(1 << B_P3),
                   7'(1 << B_JOY), 7'(1 << B_REC)};
    push_pos   = '{4'b0001, 4'b0010, 4'b0100, 4'b1000};
    // walk from lowest to highest priority so the winner lands last
    for (int i = 6; i >= 0; i--) begin
      if ((l[6:0] & single_pos[i]) != 7'd0) code = 5'(22 + i);
    end
    for (int i = 6; i >= 0; i--) begin
      if ((r[6:0] & single_pos[i]) != 7'd0) code = 5'(15 + i);
    end
    for (int i = 3; i >= 0; i--) begin
      if (l[B_TRIG] && ((l[5:2] & push_pos[i]) != 4'd0)) code = 5'(11 + i);
    end
    for (int i = 3; i >= 0; i--) begin
      if (r[B_TRIG] && ((r[5:2] & push_pos[i]) != 4'd0)) code = 5'(7 + i);
    end
    for (int i = 5; i >= 0; i--) begin
      if (((r[6:0] & both_pos[i]) != 7'd0) && ((l[6:0] & both_pos[i]) != 7'd0)) begin
        code = 5'(1 + i);
      end
    end
    return code;
  endfunction

endpackage

### design/dual_joystick_ring_watchdog.sv
// Dual joystick ring watchdog.
// Input queue port: in_push / in_full carry one item per transaction, either a
// ring update (axes and buttons of one ring) or a one millisecond tick with
// both link flags. Result queue port: out_empty / out_pop; the oldest result
// sits on out_data while out_empty is low. Every item gives exactly one result.
// Config port: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready;
// write only while no items are in flight. Unknown indexes are dropped.
// An accepted item is written into the middle queue, then shaped and written
// into the output buffer, from which out_data shows it. Throughput: one item
// per cycle while in_full is low, set by the ring state update in the front
// end; the back end shapes one queued item per cycle while its buffer has room.
// Reset (rst_n low, synchronous): all ring state, counters and the fault clear,
// config returns to its defaults, both queues empty.
// When the receiver stalls, two results wait in the output buffer and two
// more in the middle queue; then in_full rises until out_pop drains a slot.
module dual_joystick_ring_watchdog import djrw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_t         in_data,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  shape_cfg_t shape_cfg;
  logic       q_push, q_full, q_pop, q_valid;
  snap_t      q_in, q_out;

  djrw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .shape_cfg (shape_cfg),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_full    (q_full)
  );

  djrw_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .valid (q_valid)
  );

  djrw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .shape_cfg (shape_cfg),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // An emergency stop always comes with the fault set
  a_pulse_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.estop_pulse) |-> out_data.fault)
    else $error("estop pulse without fault");

  // Shaped drive_x and dome_y stay within -100..100
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ($signed(out_data.drive_x) <= 8'sd100 &&
                    $signed(out_data.drive_x) >= -8'sd100 &&
                    $signed(out_data.dome_y) <= 8'sd100 &&
                    $signed(out_data.dome_y) >= -8'sd100))
    else $error("axis out of range");

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

  // An accepted item reaches the middle queue on the next cycle
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> q_valid)
    else $error("accepted item lost");
`endif

endmodule

### design/djrw_front.sv
module djrw_front import djrw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_t         in_data,
  output logic        in_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output shape_cfg_t  shape_cfg,
  output logic        q_push,
  output snap_t       q_data,
  input  logic        q_full
);

  logic [15:0] act_to_r, inact_to_r;
  logic [6:0]  db_x_r, db_y_r;
  logic        crit_r;

  logic signed [7:0] drv_x_r, drv_y_r, dom_x_r, dom_y_r;
  logic signed [7:0] drv_x_nxt, drv_y_nxt, dom_x_nxt, dom_y_nxt;
  logic [7:0]  drv_btn_r, dom_btn_r, drv_btn_nxt, dom_btn_nxt;
  logic [16:0] drv_el_r, dom_el_r, drv_el_nxt, dom_el_nxt;
  logic        fault_r, fault_nxt, pulse;
  logic [16:0] limit;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign shape_cfg = '{deadband_x: db_x_r, deadband_y: db_y_r};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_to_r   <= 16'd200;
      inact_to_r <= 16'd10000;
      db_x_r     <= 7'd16;
      db_y_r     <= 7'd16;
      crit_r     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ACTIVE_TIMEOUT:   act_to_r   <= cfg_data;
        CFG_INACTIVE_TIMEOUT: inact_to_r <= cfg_data;
        CFG_DEADBAND_X:       db_x_r     <= cfg_data[6:0];
        CFG_DEADBAND_Y:       db_y_r     <= cfg_data[6:0];
        CFG_CRITICAL_MODE:    crit_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Apply an update or a tick to the ring state
  always_comb begin
    drv_x_nxt   = drv_x_r;
    drv_y_nxt   = drv_y_r;
    drv_btn_nxt = drv_btn_r;
    dom_x_nxt   = dom_x_r;
    dom_y_nxt   = dom_y_r;
    dom_btn_nxt = dom_btn_r;
    drv_el_nxt  = drv_el_r;
    dom_el_nxt  = dom_el_r;
    fault_nxt   = fault_r;
    pulse       = 1'b0;
    limit       = {1'b0, crit_r ? act_to_r : inact_to_r};
    if (in_data.cmd == CMD_UPDATE) begin
      if (in_data.ring_sel == RING_DRIVE) begin
        drv_x_nxt   = in_data.joy_x;
        drv_y_nxt   = in_data.joy_y;
        drv_btn_nxt = in_data.buttons;
        drv_el_nxt  = 17'd0;
      end else begin
        dom_x_nxt   = in_data.joy_x;
        dom_y_nxt   = in_data.joy_y;
        dom_btn_nxt = in_data.buttons;
        dom_el_nxt  = 17'd0;
      end
    end else begin
      if (drv_el_r != ELAPSED_MAX) drv_el_nxt = drv_el_r + 17'd1;
      if (dom_el_r != ELAPSED_MAX) dom_el_nxt = dom_el_r + 17'd1;
      if ((drv_el_nxt > limit) || (dom_el_nxt > limit)) begin
        fault_nxt = 1'b1;
        pulse     = !fault_r;
      end else if (in_data.drive_connected && in_data.dome_connected) begin
        fault_nxt = 1'b0;
      end
    end
  end

  // Hold ring state until an item is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drv_x_r   <= '0;
      drv_y_r   <= '0;
      drv_btn_r <= '0;
      dom_x_r   <= '0;
      dom_y_r   <= '0;
      dom_btn_r <= '0;
      drv_el_r  <= '0;
      dom_el_r  <= '0;
      fault_r   <= 1'b0;
    end else if (accept) begin
      drv_x_r   <= drv_x_nxt;
      drv_y_r   <= drv_y_nxt;
      drv_btn_r <= drv_btn_nxt;
      dom_x_r   <= dom_x_nxt;
      dom_y_r   <= dom_y_nxt;
      dom_btn_r <= dom_btn_nxt;
      drv_el_r  <= drv_el_nxt;
      dom_el_r  <= dom_el_nxt;
      fault_r   <= fault_nxt;
    end
  end

  assign q_push = accept;
  assign q_data = '{fault: fault_nxt, estop_pulse: pulse,
                    drv_x: drv_x_nxt, drv_y: drv_y_nxt, drv_btn: drv_btn_nxt,
                    dom_x: dom_x_nxt, dom_y: dom_y_nxt, dom_btn: dom_btn_nxt};

endmodule

### design/djrw_fifo.sv
module djrw_fifo import djrw_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  snap_t din,
  output logic  full,
  input  logic  pop,
  output snap_t dout,
  output logic  valid
);

  snap_t      mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = mem_r[rptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= din;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= !wptr_r;
      if (do_pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### design/djrw_back.sv
module djrw_back import djrw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  shape_cfg_t shape_cfg,
  input  logic       q_valid,
  input  snap_t      q_data,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output out_t       out_data
);

  out_t       obuf_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       take, give;
  out_t       res;

  // Shape axes and encode the chord
  always_comb begin
    res.fault        = q_data.fault;
    res.estop_pulse  = q_data.estop_pulse;
    res.drive_x      = shape_axis(q_data.drv_x, shape_cfg.deadband_x);
    res.drive_y      = shape_axis(q_data.drv_y, shape_cfg.deadband_y);
    res.dome_x       = shape_axis(q_data.dom_x, shape_cfg.deadband_x);
    res.dome_y       = shape_axis(q_data.dom_y, shape_cfg.deadband_y);
    res.trigger_code = chord_code(q_data.drv_btn, q_data.dom_btn);
  end

  assign take      = q_valid && (cnt_r != 2'd2);
  assign give      = out_pop && (cnt_r != 2'd0);
  assign q_pop     = take;
  assign out_empty = (cnt_r == 2'd0);
  assign out_data  = obuf_r[rptr_r];

  // Store results
  always_ff @(posedge clk) begin
    if (take) obuf_r[wptr_r] <= res;
  end

  // Advance output pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (take) wptr_r <= !wptr_r;
      if (give) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(take) - 2'(give);
    end
  end

endmodule

### sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import djrw_pkg::*;

  // Register indexes that map to no register
  localparam logic [2:0] CFG_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CFG_LAST_UNUSED  = 3'd7;

  localparam int STALL_LIMIT  = 400;
  localparam int MAX_REPORTS  = 100;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 190;
  localparam int BURST_TICKS  = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  in_t         in_data = '0;
  logic        in_full;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dual_joystick_ring_watchdog dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Ring state and settings mirrored by the predictor
  logic signed [7:0] drv_x, drv_y, dom_x, dom_y;
  logic [7:0]        drv_btn, dom_btn;
  logic [16:0]       drv_age, dom_age;
  logic              fault_q;
  logic [15:0]       act_limit, idle_limit;
  logic [6:0]        band_x, band_y;
  logic              crit;

  out_t pending_results[$];

  // Directed stimulus plan
  typedef struct {
    logic        is_cfg;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    in_t         item;
    logic        pinned;
    out_t        want;
  } step_t;
  step_t plan[$];

  int   errors = 0;
  int   reports = 0;
  int   n_updates = 0;
  int   n_ticks = 0;
  int   n_pulses = 0;
  int   n_cfg = 0;
  int   n_results = 0;
  int   quiet_cycles = 0;
  logic in_rush = 1'b0;
  logic out_burst = 1'b0;
  out_t want_r;

  function automatic void clear_model();
    drv_x = '0; drv_y = '0; drv_btn = '0;
    dom_x = '0; dom_y = '0; dom_btn = '0;
    drv_age = '0; dom_age = '0;
    fault_q = 1'b0;
    act_limit = 16'd200;
    idle_limit = 16'd10000;
    band_x = 7'd16;
    band_y = 7'd16;
    crit = 1'b0;
  endfunction

  // Deadband, then scale by 100/127 truncating toward zero
  function automatic logic signed [7:0] scale_axis(logic signed [7:0] raw, logic [6:0] band);
    int v, mag;
    v = raw;
    mag = (v < 0) ? -v : v;
    if (mag < int'(band)) return 8'sd0;
    return 8'((v * 100) / 127);
  endfunction

  // First matching chord wins, highest priority first
  function automatic logic [4:0] chord_of(logic [7:0] r, logic [7:0] l);
    int pair_bits[6] = '{B_TRIG, B_P1, B_P2, B_P3, B_JOY, B_REC};
    int push_bits[4] = '{B_P1, B_P2, B_P3, B_P4};
    int solo_bits[7] = '{B_TRIG, B_P1, B_P2, B_P3, B_P4, B_JOY, B_REC};
    for (int i = 0; i < 6; i++)
      if (r[pair_bits[i]] && l[pair_bits[i]]) return 5'(1 + i);
    for (int i = 0; i < 4; i++)
      if (r[B_TRIG] && r[push_bits[i]]) return 5'(7 + i);
    for (int i = 0; i < 4; i++)
      if (l[B_TRIG] && l[push_bits[i]]) return 5'(11 + i);
    for (int i = 0; i < 7; i++)
      if (r[solo_bits[i]]) return 5'(15 + i);
    for (int i = 0; i < 7; i++)
      if (l[solo_bits[i]]) return 5'(22 + i);
    return 5'd0;
  endfunction

  // Advance the ring state by one item and form its result
  function automatic out_t ring_result(in_t it);
    out_t        res;
    logic [16:0] lim;
    logic        pulse;
    pulse = 1'b0;
    if (it.cmd == CMD_UPDATE) begin
      if (it.ring_sel == RING_DRIVE) begin
        drv_x = it.joy_x; drv_y = it.joy_y; drv_btn = it.buttons;
        drv_age = '0;
      end else begin
        dom_x = it.joy_x; dom_y = it.joy_y; dom_btn = it.buttons;
        dom_age = '0;
      end
    end else begin
      lim = crit ? {1'b0, act_limit} : {1'b0, idle_limit};
      if (drv_age != ELAPSED_MAX) drv_age = drv_age + 17'd1;
      if (dom_age != ELAPSED_MAX) dom_age = dom_age + 17'd1;
      if (drv_age > lim || dom_age > lim) begin
        if (!fault_q) begin
          fault_q = 1'b1;
          pulse = 1'b1;
        end
      end else if (fault_q && it.drive_connected && it.dome_connected) begin
        fault_q = 1'b0;
      end
    end
    res.fault = fault_q;
    res.estop_pulse = pulse;
    res.drive_x = scale_axis(drv_x, band_x);
    res.drive_y = scale_axis(drv_y, band_y);
    res.dome_x = scale_axis(dom_x, band_x);
    res.dome_y = scale_axis(dom_y, band_y);
    res.trigger_code = chord_of(drv_btn, dom_btn);
    return res;
  endfunction

  function automatic string fmt_res(out_t r);
    return $sformatf("fault=%0b estop=%0b drive=(%0d,%0d) dome=(%0d,%0d) code=%0d",
                     r.fault, r.estop_pulse, $signed(r.drive_x), $signed(r.drive_y),
                     $signed(r.dome_x), $signed(r.dome_y), r.trigger_code);
  endfunction

  function automatic in_t mk_upd(logic ring, int x, int y, logic [7:0] b);
    in_t it;
    it = '0;
    it.cmd = CMD_UPDATE;
    it.ring_sel = ring;
    it.joy_x = 8'(x);
    it.joy_y = 8'(y);
    it.buttons = b;
    return it;
  endfunction

  function automatic in_t mk_tick(logic dc, logic mc);
    in_t it;
    it = '0;
    it.cmd = CMD_TICK;
    it.drive_connected = dc;
    it.dome_connected = mc;
    return it;
  endfunction

  function automatic out_t mk_res(logic f, logic p, int dx, int dy, int mx, int my, int code);
    out_t r;
    r.fault = f;
    r.estop_pulse = p;
    r.drive_x = 8'(dx);
    r.drive_y = 8'(dy);
    r.dome_x = 8'(mx);
    r.dome_y = 8'(my);
    r.trigger_code = 5'(code);
    return r;
  endfunction

  function automatic void plan_item(in_t it, logic pin, out_t want);
    step_t s;
    s.is_cfg = 1'b0;
    s.reg_idx = '0;
    s.reg_val = '0;
    s.item = it;
    s.pinned = pin;
    s.want = want;
    plan.push_back(s);
  endfunction

  function automatic void plan_cfg(logic [2:0] idx, logic [15:0] val);
    step_t s;
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    s.item = '0;
    s.pinned = 1'b0;
    s.want = '0;
    plan.push_back(s);
  endfunction

  // Axis values favor the extremes and the deadband edges
  function automatic logic signed [7:0] pick_axis(logic [6:0] band);
    case ($urandom_range(0, 7))
      0: return 8'sh80;
      1: return 8'sh7F;
      2: return 8'(band);
      3: return 8'(-int'(band));
      4: return 8'(int'(band) - 1);
      default: return 8'($urandom);
    endcase
  endfunction

  // Sparse chords reach the low priority codes
  function automatic logic [7:0] pick_buttons();
    case ($urandom_range(0, 5))
      0, 1: return 8'($urandom);
      2: return 8'(1 << $urandom_range(0, 7));
      3: return 8'((1 << B_TRIG) | (1 << $urandom_range(0, 7)));
      default: return 8'($urandom & $urandom);
    endcase
  endfunction

  function automatic in_t rand_item(logic force_tick);
    in_t it;
    it.cmd = (force_tick || $urandom_range(0, 99) < 45) ? CMD_TICK : CMD_UPDATE;
    it.ring_sel = 1'($urandom_range(0, 1));
    it.joy_x = pick_axis(band_x);
    it.joy_y = pick_axis(band_y);
    it.buttons = pick_buttons();
    it.drive_connected = ($urandom_range(0, 9) != 0);
    it.dome_connected = ($urandom_range(0, 9) != 0);
    return it;
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(100, 2000));
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [15:0] pick_band();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd127;
      default: return 16'($urandom_range(0, 127));
    endcase
  endfunction

  // Push one item and record its expected result once the transaction lands
  task automatic send_item(in_t it, logic pin, out_t want);
    int   gap;
    out_t got;
    gap = in_rush ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    got = ring_result(it);
    pending_results.push_back(pin ? want : got);
    if (it.cmd == CMD_TICK) n_ticks++;
    else n_updates++;
    if (got.estop_pulse) n_pulses++;
  endtask

  // Hold the sender until every expected result has been popped
  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ACTIVE_TIMEOUT:   act_limit = val;
      CFG_INACTIVE_TIMEOUT: idle_limit = val;
      CFG_DEADBAND_X:       band_x = val[6:0];
      CFG_DEADBAND_Y:       band_y = val[6:0];
      CFG_CRITICAL_MODE:    crit = val[0];
      default: ;
    endcase
    n_cfg++;
    @(posedge clk);
  endtask

  // Pop results with random stalls and calm stretches
  initial begin
    int   gap;
    int   left;
    logic calm;
    left = 0;
    calm = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        left = $urandom_range(10, 80);
      end
      left--;
      gap = (calm || out_burst) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  // Compare each popped result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: result with nothing pending: expected none, got %s",
                   $time, fmt_res(out_data));
        end
      end else begin
        want_r = pending_results.pop_front();
        if (out_data.fault !== want_r.fault ||
            out_data.estop_pulse !== want_r.estop_pulse ||
            out_data.drive_x !== want_r.drive_x ||
            out_data.drive_y !== want_r.drive_y ||
            out_data.dome_x !== want_r.dome_x ||
            out_data.dome_y !== want_r.dome_y ||
            out_data.trigger_code !== want_r.trigger_code) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: result mismatch: expected %s, got %s",
                     $time, fmt_res(want_r), fmt_res(out_data));
          end
        end
      end
    end
  end

  // End the run when no transaction of any kind moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("dual_joystick_ring_watchdog: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int   sent;
    int   seg;
    logic tick_run;
    clear_model();

    // Hold reset, then release
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults after reset: scaling extremes, deadband edge, chord priorities
    plan_item(mk_tick(1'b1, 1'b1), 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0));
    plan_item(mk_upd(RING_DRIVE, 127, -128, 8'h02), 1'b1,
              mk_res(0, 0, 100, -100, 0, 0, 15));
    plan_item(mk_upd(RING_DOME, -127, 15, 8'h02), 1'b1,
              mk_res(0, 0, 100, -100, -100, 0, 1));
    plan_item(mk_upd(RING_DOME, 16, -16, 8'h80), 1'b1,
              mk_res(0, 0, 100, -100, 12, -12, 15));
    plan_item(mk_upd(RING_DRIVE, 0, 0, 8'h06), 1'b1,
              mk_res(0, 0, 0, 0, 12, -12, 7));
    plan_item(mk_upd(RING_DOME, 0, 0, 8'h7F), 1'b0, '0);
    plan_item(mk_upd(RING_DRIVE, -1, 1, 8'h41), 1'b0, '0);
    plan_item(mk_upd(RING_DRIVE, 0, 0, 8'h00), 1'b0, '0);
    plan_item(mk_upd(RING_DOME, 0, 0, 8'h12), 1'b0, '0);
    plan_item(mk_upd(RING_DOME, 0, 0, 8'h40), 1'b0, '0);
    plan_item(mk_upd(RING_DRIVE, -128, 127, 8'hFF), 1'b0, '0);

    // Zero active timeout: first tick faults, second leaves it latched
    plan_cfg(CFG_CRITICAL_MODE, 16'd1);
    plan_cfg(CFG_ACTIVE_TIMEOUT, 16'd0);
    plan_cfg(CFG_DEADBAND_X, 16'd0);
    plan_cfg(CFG_DEADBAND_Y, 16'd127);
    plan_item(mk_tick(1'b1, 1'b1), 1'b0, '0);
    plan_item(mk_tick(1'b1, 1'b1), 1'b0, '0);

    // Fault clears only with both links up
    plan_cfg(CFG_ACTIVE_TIMEOUT, 16'hFFFF);
    plan_item(mk_upd(RING_DOME, 5, -5, 8'h20), 1'b0, '0);
    plan_item(mk_tick(1'b0, 1'b1), 1'b0, '0);
    plan_item(mk_tick(1'b1, 1'b0), 1'b0, '0);
    plan_item(mk_tick(1'b1, 1'b1), 1'b0, '0);

    // Inactive timeout path; a write to an unused index must change nothing
    plan_cfg(CFG_CRITICAL_MODE, 16'd0);
    plan_cfg(CFG_INACTIVE_TIMEOUT, 16'd0);
    plan_cfg(CFG_LAST_UNUSED, 16'hFFFF);
    plan_item(mk_tick(1'b1, 1'b0), 1'b0, '0);
    plan_cfg(CFG_INACTIVE_TIMEOUT, 16'hFFFF);
    plan_cfg(CFG_DEADBAND_X, 16'd127);
    plan_cfg(CFG_DEADBAND_Y, 16'd0);
    plan_item(mk_upd(RING_DRIVE, 127, -128, 8'h20), 1'b0, '0);
    plan_item(mk_upd(RING_DOME, -128, 127, 8'h22), 1'b0, '0);
    plan_item(mk_tick(1'b1, 1'b1), 1'b0, '0);

    // Walk the plan; register writes wait for an idle block
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        cfg_write(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].item, plan[i].pinned, plan[i].want);
      end
    end

    // Back-to-back ticks with the receiver popping every cycle
    drain_results();
    cfg_write(CFG_CRITICAL_MODE, 16'd0);
    cfg_write(CFG_INACTIVE_TIMEOUT, 16'hFFFF);
    cfg_write(CFG_DEADBAND_X, 16'd16);
    cfg_write(CFG_DEADBAND_Y, 16'd16);
    in_rush = 1'b1;
    out_burst = 1'b1;
    for (int k = 0; k < BURST_TICKS; k++) send_item(rand_item(1'b1), 1'b0, '0);
    out_burst = 1'b0;

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      cfg_write(CFG_ACTIVE_TIMEOUT, pick_limit());
      cfg_write(CFG_INACTIVE_TIMEOUT, pick_limit());
      cfg_write(CFG_DEADBAND_X, pick_band());
      cfg_write(CFG_DEADBAND_Y, pick_band());
      cfg_write(CFG_CRITICAL_MODE, 16'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0)
        cfg_write(3'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)), 16'($urandom));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        in_rush = ($urandom_range(0, 3) == 0);
        tick_run = ($urandom_range(0, 9) < 3);
        seg = tick_run ? $urandom_range(5, 60) : $urandom_range(1, 30);
        for (int k = 0; k < seg; k++) send_item(rand_item(tick_run), 1'b0, '0);
        sent += seg;
      end
    end

    // Drain, then allow a few more cycles for stray results
    in_rush = 1'b0;
    drain_results();
    repeat (6) @(posedge clk);

    $display("Covered %0d updates and %0d ticks (%0d in one back-to-back burst), %0d e-stops,",
             n_updates, n_ticks, BURST_TICKS, n_pulses);
    $display("%0d register writes in %0d random phases, %0d results checked.",
             n_cfg, PHASES, n_results);
    if (errors == 0) begin
      $display("dual_joystick_ring_watchdog: match");
    end else begin
      $display("dual_joystick_ring_watchdog: mismatch");
    end
    $finish;
  end

endmodule
